/* rtl/bicubic_bspline_patch_eval_core_assert.svh */
// assertion macros shared by the bicubic b-spline patch evaluator checkers
`ifndef BICUBIC_BSPLINE_PATCH_EVAL_CORE_ASSERT_SVH
`define BICUBIC_BSPLINE_PATCH_EVAL_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BBPE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BBPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bbpe_pkg.sv */
// constants and types shared by the bicubic b-spline patch evaluator
package bbpe_pkg;

    localparam int GRID_ROWS  = 16;
    localparam int GRID_COLS  = 16;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 12;

    localparam int ACTION_BITS = 1;
    localparam int ROW_BITS    = 4;
    localparam int COL_BITS    = 4;
    localparam int ERR_BITS    = 1;

    localparam logic [ACTION_BITS-1:0] ACTION_LOAD = 1'b0;
    localparam logic [ACTION_BITS-1:0] ACTION_EVAL = 1'b1;

    localparam int ADDR_BITS  = $clog2(GRID_ROWS * GRID_COLS);
    localparam int GRID_DEPTH = GRID_ROWS * GRID_COLS;
    localparam int POINT_BITS = 3 * COORD_BITS;

    // input tdata layout, lowest bit first
    localparam int IN_ROW_LSB   = 0;
    localparam int IN_COL_LSB   = IN_ROW_LSB + ROW_BITS;
    localparam int IN_X_LSB     = IN_COL_LSB + COL_BITS;
    localparam int IN_Y_LSB     = IN_X_LSB + COORD_BITS;
    localparam int IN_Z_LSB     = IN_Y_LSB + COORD_BITS;
    localparam int IN_U_LSB     = IN_Z_LSB + COORD_BITS;
    localparam int IN_V_LSB     = IN_U_LSB + FRAC_BITS;
    localparam int IN_RAW_BITS  = IN_V_LSB + FRAC_BITS;
    localparam int IN_TDATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((POINT_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;

endpackage

/* rtl/bicubic_bspline_patch_eval_core.sv */
// Uniform bicubic B-spline surface evaluator over a 16x16 grid of 3D control points.
// A load transaction (action 0) writes one point into the grid ram and the block stays
// ready. An evaluate transaction (action 1) first computes the u and v basis weights on the
// one shared multiplier (cubes, then a reciprocal multiply for the divide by six), then
// reads one control point per cycle from the single read port of the grid ram and multiply-
// accumulates it, drains the read/multiply pipeline, and finally rounds and saturates into
// the result register once that register is free. An evaluate whose 4x4 patch leaves the
// grid skips these steps and returns zeros with range_error set. A finished result waits in
// the output register while the next transaction is accepted. Points must be loaded before
// a patch that covers them is evaluated; the ram has no reset.
module bicubic_bspline_patch_eval_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // row, col, coord_x, coord_y, coord_z, u_param, v_param
    input  logic [bbpe_pkg::IN_TDATA_BITS-1:0]     i_s_axis_tdata,
    // action
    input  logic [bbpe_pkg::ACTION_BITS-1:0]       i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // surf_x, surf_y, surf_z
    output logic [bbpe_pkg::OUT_TDATA_BITS-1:0]    o_m_axis_tdata,
    // range_error
    output logic [bbpe_pkg::ERR_BITS-1:0]          o_m_axis_tuser
);

    import bbpe_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_ACCUM = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [2:0] STEP_U2 = 3'd0;
    localparam logic [2:0] STEP_U3 = 3'd1;
    localparam logic [2:0] STEP_T2 = 3'd2;
    localparam logic [2:0] STEP_T3 = 3'd3;
    localparam logic [2:0] STEP_B0 = 3'd4;
    localparam logic [2:0] STEP_B1 = 3'd5;
    localparam logic [2:0] STEP_B3 = 3'd6;
    localparam logic [2:0] STEP_B2 = 3'd7;

    localparam int WGT_BITS   = FRAC_BITS + 1;
    localparam int SQ_BITS    = 2 * FRAC_BITS;
    localparam int T2_BITS    = 2 * FRAC_BITS + 1;
    localparam int U3_BITS    = 3 * FRAC_BITS;
    localparam int T3_BITS    = 3 * FRAC_BITS + 1;
    localparam int W1_BITS    = 3 * FRAC_BITS + 4;
    localparam int X_BITS     = FRAC_BITS + 3;
    localparam int RECIP_BITS = 16;
    localparam int RECIP_SHIFT = 18;
    localparam logic [RECIP_BITS-1:0] RECIP6 = 16'd43691;
    localparam int MA_BITS    = 2 * FRAC_BITS + 2;
    localparam int MB_BITS    = (WGT_BITS > RECIP_BITS) ? WGT_BITS : RECIP_BITS;
    localparam int MP_BITS    = MA_BITS + MB_BITS;
    localparam int PW_BITS    = 2 * WGT_BITS;
    localparam int CP_BITS    = PW_BITS + 1 + COORD_BITS;
    localparam int ACC_BITS   = 2 * FRAC_BITS + COORD_BITS + 2;
    localparam int RES_SHIFT  = 2 * FRAC_BITS;

    localparam logic [WGT_BITS-1:0] ONE_W   = WGT_BITS'(1) << FRAC_BITS;
    localparam logic [W1_BITS-1:0]  HALF_W  = W1_BITS'(3) << (2 * FRAC_BITS);
    localparam logic [W1_BITS-1:0]  FOUR_S3 = W1_BITS'(4) << (3 * FRAC_BITS);
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (RES_SHIFT - 1);
    localparam logic signed [ACC_BITS-1:0] COORD_MAX  =
        (ACC_BITS'(1) << (COORD_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] COORD_MIN  = ~COORD_MAX;

    // control
    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_par, n_par;
    logic [3:0] r_cnt, n_cnt;
    logic       r_v1, r_v2;
    logic       r_out_valid, n_out_valid;

    // payload
    logic [ROW_BITS-1:0]  r_row;
    logic [COL_BITS-1:0]  r_col;
    logic [FRAC_BITS-1:0] r_u, r_v;
    logic                 r_err;
    logic [SQ_BITS-1:0]   r_u2;
    logic [T2_BITS-1:0]   r_t2;
    logic [U3_BITS-1:0]   r_w3;
    logic [T3_BITS-1:0]   r_w0;
    logic [WGT_BITS-1:0]  r_wu [4];
    logic [WGT_BITS-1:0]  r_wv [4];
    logic [PW_BITS-1:0]   r_w;
    logic signed [ACC_BITS-1:0] r_prod [3];
    logic signed [ACC_BITS-1:0] r_acc [3];
    logic [POINT_BITS-1:0] r_out_data;
    logic                  r_out_err;

    // input fields
    logic [ACTION_BITS-1:0] in_action;
    logic [ROW_BITS-1:0]    in_row;
    logic [COL_BITS-1:0]    in_col;
    logic [FRAC_BITS-1:0]   in_u, in_v;
    logic [POINT_BITS-1:0]  in_point;
    logic                   in_accept;
    logic                   in_fit;
    logic                   out_load;

    // shared multiplier
    logic [MA_BITS-1:0]  mul_a;
    logic [MB_BITS-1:0]  mul_b;
    logic [MP_BITS-1:0]  mul_p;
    logic [WGT_BITS-1:0] mul_q;

    logic [FRAC_BITS-1:0] p_u;
    logic [WGT_BITS-1:0]  p_t;
    logic [W1_BITS-1:0]   w1, sum0, sum1, sum3;
    logic [X_BITS-1:0]    x0, x1, x3;
    logic [WGT_BITS-1:0]  b2;

    logic                  ram_we;
    logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
    logic [POINT_BITS-1:0] ram_rdata;
    logic [ROW_BITS-1:0]   rd_row;
    logic [COL_BITS-1:0]   rd_col;

    logic signed [PW_BITS:0]    w_sig;
    logic signed [CP_BITS-1:0]  c_prod [3];
    logic [POINT_BITS-1:0]      fin_data;

    assign in_action = i_s_axis_tuser;
    assign in_row    = i_s_axis_tdata[IN_ROW_LSB +: ROW_BITS];
    assign in_col    = i_s_axis_tdata[IN_COL_LSB +: COL_BITS];
    assign in_point  = i_s_axis_tdata[IN_X_LSB +: POINT_BITS];
    assign in_u      = i_s_axis_tdata[IN_U_LSB +: FRAC_BITS];
    assign in_v      = i_s_axis_tdata[IN_V_LSB +: FRAC_BITS];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_fit          = (int'(in_row) + 3 < GRID_ROWS) && (int'(in_col) + 3 < GRID_COLS);
    assign out_load        = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    // grid ram, one point per entry as {z, y, x}
    assign ram_we    = in_accept && (in_action == ACTION_LOAD)
                       && (int'(in_row) < GRID_ROWS) && (int'(in_col) < GRID_COLS);
    assign ram_waddr = ADDR_BITS'(int'(in_row) * GRID_COLS + int'(in_col));
    assign rd_row    = r_row + ROW_BITS'(r_cnt[3:2]);
    assign rd_col    = r_col + COL_BITS'(r_cnt[1:0]);
    assign ram_raddr = ADDR_BITS'(int'(rd_row) * GRID_COLS + int'(rd_col));

    bbpe_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_point),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // basis weight terms: t = 1 - u, w0 = t^3, w3 = u^3, w1 = 3u^3 - 6u^2 + 4 (scaled by s^3)
    assign p_u  = r_par ? r_v : r_u;
    assign p_t  = ONE_W - {1'b0, p_u};
    assign w1   = (W1_BITS'(r_w3) << 1) + W1_BITS'(r_w3) + FOUR_S3
                  - ((W1_BITS'(r_u2) << (FRAC_BITS + 2)) + (W1_BITS'(r_u2) << (FRAC_BITS + 1)));
    assign sum0 = W1_BITS'(r_w0) + HALF_W;
    assign sum1 = w1 + HALF_W;
    assign sum3 = W1_BITS'(r_w3) + HALF_W;
    assign x0   = sum0[RES_SHIFT +: X_BITS];
    assign x1   = sum1[RES_SHIFT +: X_BITS];
    assign x3   = sum3[RES_SHIFT +: X_BITS];
    assign b2   = r_par ? (ONE_W - r_wv[0] - r_wv[1] - r_wv[3])
                        : (ONE_W - r_wu[0] - r_wu[1] - r_wu[3]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_SETUP: begin
                case (r_step)
                    STEP_U2: begin
                        mul_a = MA_BITS'(p_u);
                        mul_b = MB_BITS'(p_u);
                    end
                    STEP_U3: begin
                        mul_a = MA_BITS'(r_u2);
                        mul_b = MB_BITS'(p_u);
                    end
                    STEP_T2: begin
                        mul_a = MA_BITS'(p_t);
                        mul_b = MB_BITS'(p_t);
                    end
                    STEP_T3: begin
                        mul_a = MA_BITS'(r_t2);
                        mul_b = MB_BITS'(p_t);
                    end
                    STEP_B0: begin
                        mul_a = MA_BITS'(x0);
                        mul_b = MB_BITS'(RECIP6);
                    end
                    STEP_B1: begin
                        mul_a = MA_BITS'(x1);
                        mul_b = MB_BITS'(RECIP6);
                    end
                    STEP_B3: begin
                        mul_a = MA_BITS'(x3);
                        mul_b = MB_BITS'(RECIP6);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_ACCUM: begin
                mul_a = MA_BITS'(r_wu[r_cnt[3:2]]);
                mul_b = MB_BITS'(r_wv[r_cnt[1:0]]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    // divide by six through the reciprocal, exact for x below 2^17
    assign mul_q = mul_p[RECIP_SHIFT +: WGT_BITS];

    // weighted point products, one per coordinate
    assign w_sig = signed'({1'b0, r_w});
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c_prod[c] = w_sig * t_coord'(ram_rdata[c*COORD_BITS +: COORD_BITS]);
        end
    end

    // round half up and saturate
    always_comb begin
        logic signed [ACC_BITS-1:0] rnd;
        logic signed [ACC_BITS-1:0] q;
        fin_data = '0;
        for (int c = 0; c < 3; c++) begin
            rnd = r_acc[c] + ROUND_HALF;
            q   = rnd >>> RES_SHIFT;
            if (q > COORD_MAX) begin
                fin_data[c*COORD_BITS +: COORD_BITS] = COORD_MAX[COORD_BITS-1:0];
            end else if (q < COORD_MIN) begin
                fin_data[c*COORD_BITS +: COORD_BITS] = COORD_MIN[COORD_BITS-1:0];
            end else begin
                fin_data[c*COORD_BITS +: COORD_BITS] = q[COORD_BITS-1:0];
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_par       = r_par;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_accept && (in_action == ACTION_EVAL)) begin
                    n_step  = STEP_U2;
                    n_par   = 1'b0;
                    n_cnt   = '0;
                    n_state = in_fit ? ST_SETUP : ST_DONE;
                end
            end
            ST_SETUP: begin
                n_step = r_step + 3'd1;
                if (r_step == STEP_B2) begin
                    n_par = 1'b1;
                    if (r_par) begin
                        n_state = ST_ACCUM;
                    end
                end
            end
            ST_ACCUM: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_U2;
            r_par       <= 1'b0;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_par       <= n_par;
            r_cnt       <= n_cnt;
            r_v1        <= (r_state == ST_ACCUM);
            r_v2        <= r_v1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && (in_action == ACTION_EVAL)) begin
            r_row <= in_row;
            r_col <= in_col;
            r_u   <= in_u;
            r_v   <= in_v;
            r_err <= !in_fit;
        end

        if (r_state == ST_SETUP) begin
            case (r_step)
                STEP_U2: r_u2 <= mul_p[SQ_BITS-1:0];
                STEP_U3: r_w3 <= mul_p[U3_BITS-1:0];
                STEP_T2: r_t2 <= mul_p[T2_BITS-1:0];
                STEP_T3: r_w0 <= mul_p[T3_BITS-1:0];
                STEP_B0: begin
                    if (r_par) r_wv[0] <= mul_q;
                    else       r_wu[0] <= mul_q;
                end
                STEP_B1: begin
                    if (r_par) r_wv[1] <= mul_q;
                    else       r_wu[1] <= mul_q;
                end
                STEP_B3: begin
                    if (r_par) r_wv[3] <= mul_q;
                    else       r_wu[3] <= mul_q;
                end
                default: begin
                    if (r_par) r_wv[2] <= b2;
                    else       r_wu[2] <= b2;
                end
            endcase
        end

        // weight product is registered so that it lines up with the registered ram read data
        if (r_state == ST_ACCUM) begin
            r_w <= mul_p[PW_BITS-1:0];
        end

        for (int c = 0; c < 3; c++) begin
            if (r_v1) begin
                r_prod[c] <= ACC_BITS'(c_prod[c]);
            end
            if (in_accept) begin
                r_acc[c] <= '0;
            end else if (r_v2) begin
                r_acc[c] <= r_acc[c] + r_prod[c];
            end
        end

        if (out_load) begin
            r_out_data <= r_err ? '0 : fin_data;
            r_out_err  <= r_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_BITS'(r_out_data);
    assign o_m_axis_tuser  = r_out_err;

endmodule

/* rtl/bbpe_ram.sv */
// generic single-write, single-read ram with registered read data
module bbpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/bbpe_checker.sv */
// port-level checks for the bicubic b-spline patch evaluator, bound to the top level
`include "bicubic_bspline_patch_eval_core_assert.svh"

module bbpe_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    // row, col, coord_x, coord_y, coord_z, u_param, v_param
    input logic [bbpe_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // action
    input logic [bbpe_pkg::ACTION_BITS-1:0]    i_s_axis_tuser,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    // surf_x, surf_y, surf_z
    input logic [bbpe_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    // range_error
    input logic [bbpe_pkg::ERR_BITS-1:0]       o_m_axis_tuser
);

    import bbpe_pkg::*;

    logic in_xact;
    assign in_xact = i_s_axis_tvalid && o_s_axis_tready;

    `BBPE_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")

    `BBPE_ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, in_xact && (i_s_axis_tuser == ACTION_EVAL), !o_s_axis_tready, "ready right after an evaluate transaction")

    `BBPE_ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, in_xact && (i_s_axis_tuser == ACTION_LOAD), o_s_axis_tready, "not ready after a load transaction")

    `BBPE_ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == '0, "range error with nonzero point")

    `BBPE_ASSERT_SAME(a_result_frees, i_clk, i_rst_n, $rose(o_m_axis_tvalid), o_s_axis_tready, "result posted while still busy")

endmodule

bind bicubic_bspline_patch_eval_core bbpe_checker u_bbpe_checker (.*);

/* test/testbench.sv */
// self-checking testbench for the bicubic b-spline patch evaluator core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbpe_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
    localparam int HOLD_CYCLES  = 400;
    // longest quiet stretch of a good run is the hold-off plus one evaluation
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;

    localparam longint UNIT_Q    = longint'(1) << FRAC_BITS;
    localparam longint ROUND_BIT = longint'(1) << (2 * FRAC_BITS - 1);
    localparam longint COORD_HI  = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO  = -COORD_HI - 1;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef logic [FRAC_BITS-1:0] t_frac;
    typedef logic [ROW_BITS-1:0]  t_row;
    typedef logic [COL_BITS-1:0]  t_col;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic [ERR_BITS-1:0] err;
    } t_surface;

    typedef struct {
        logic [ACTION_BITS-1:0] action;
        t_row     row;
        t_col     col;
        t_coord   x;
        t_coord   y;
        t_coord   z;
        t_frac    u;
        t_frac    v;
        bit       typed;
        t_surface want;
    } t_patch_item;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_s_axis_tvalid;
    logic                        o_s_axis_tready;
    logic [IN_TDATA_BITS-1:0]    i_s_axis_tdata;
    logic [ACTION_BITS-1:0]      i_s_axis_tuser;
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]   o_m_axis_tdata;
    logic [ERR_BITS-1:0]         o_m_axis_tuser;

    // own copy of the control grid
    t_coord grid_pts [GRID_DEPTH][3];
    bit     grid_loaded [GRID_DEPTH];

    t_surface surf_expected [$];

    int mismatches   = 0;
    int stall_cycles = 0;
    int tx_idle_pct  = 23;
    int rx_idle_pct  = 83;
    int hold_left    = -1;
    bit hold_go      = 1'b0;

    bicubic_bspline_patch_eval_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // four basis weights in q.frac, forced to sum to exactly one
    function automatic void bspline_weights(input t_frac p, output longint w[4]);
        longint u, t, s2;
        u  = longint'(p);
        t  = UNIT_Q - u;
        s2 = UNIT_Q * UNIT_Q;
        w[0] = (t * t * t + 3 * s2) / (6 * s2);
        w[1] = (3 * u * u * u + 4 * s2 * UNIT_Q - 6 * u * u * UNIT_Q + 3 * s2) / (6 * s2);
        w[3] = (u * u * u + 3 * s2) / (6 * s2);
        w[2] = UNIT_Q - w[0] - w[1] - w[3];
    endfunction

    function automatic t_coord round_saturate(input longint acc);
        longint r;
        r = (acc + ROUND_BIT) >>> (2 * FRAC_BITS);
        if (r > COORD_HI) r = COORD_HI;
        if (r < COORD_LO) r = COORD_LO;
        return r[COORD_BITS-1:0];
    endfunction

    function automatic bit patch_in_grid(input t_row row, input t_col col);
        return (int'(row) + 3 < GRID_ROWS) && (int'(col) + 3 < GRID_COLS);
    endfunction

    function automatic t_surface surface_point(input t_row row, input t_col col,
                                               input t_frac u, input t_frac v);
        t_surface res;
        longint   wu [4];
        longint   wv [4];
        longint   acc [3];
        int       idx;
        res.x = '0;
        res.y = '0;
        res.z = '0;
        res.err = 1'b1;
        if (!patch_in_grid(row, col)) return res;
        bspline_weights(u, wu);
        bspline_weights(v, wv);
        for (int c = 0; c < 3; c++) acc[c] = 0;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                idx = (int'(row) + i) * GRID_COLS + int'(col) + j;
                for (int c = 0; c < 3; c++)
                    acc[c] += wu[i] * wv[j] * longint'(grid_pts[idx][c]);
            end
        end
        res.x = round_saturate(acc[0]);
        res.y = round_saturate(acc[1]);
        res.z = round_saturate(acc[2]);
        res.err = 1'b0;
        return res;
    endfunction

    // update the grid copy or queue the point this transaction will produce
    task automatic record_item(input t_patch_item it);
        int idx;
        idx = int'(it.row) * GRID_COLS + int'(it.col);
        if (it.action == ACTION_LOAD) begin
            grid_pts[idx][0] = it.x;
            grid_pts[idx][1] = it.y;
            grid_pts[idx][2] = it.z;
            grid_loaded[idx] = 1'b1;
        end else if (it.typed) begin
            surf_expected = {surf_expected, it.want};
        end else begin
            surf_expected = {surf_expected, surface_point(it.row, it.col, it.u, it.v)};
        end
    endtask

    function automatic t_coord random_coord();
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_frac random_frac();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return t_frac'($urandom);
        endcase
    endfunction

    function automatic t_patch_item random_item();
        t_patch_item it;
        int          idx;
        bit          found;
        it.action = ($urandom_range(99) < 45) ? ACTION_LOAD : ACTION_EVAL;
        it.row    = t_row'($urandom_range(GRID_ROWS - 1));
        it.col    = t_col'($urandom_range(GRID_COLS - 1));
        it.x      = random_coord();
        it.y      = random_coord();
        it.z      = random_coord();
        it.u      = random_frac();
        it.v      = random_frac();
        it.typed  = 1'b0;
        it.want   = '{default: '0};
        found     = 1'b0;
        // an evaluation must never touch an unloaded point: load the first gap instead
        if (it.action == ACTION_EVAL && patch_in_grid(it.row, it.col)) begin
            for (int i = 0; i < 4 && !found; i++) begin
                for (int j = 0; j < 4 && !found; j++) begin
                    idx = (int'(it.row) + i) * GRID_COLS + int'(it.col) + j;
                    if (!grid_loaded[idx]) begin
                        found     = 1'b1;
                        it.action = ACTION_LOAD;
                        it.row    = t_row'(int'(it.row) + i);
                        it.col    = t_col'(int'(it.col) + j);
                    end
                end
            end
        end
        return it;
    endfunction

    task automatic drive_item(input t_patch_item it);
        logic [IN_TDATA_BITS-1:0] word;
        int                       gap;
        word = '0;
        word[IN_ROW_LSB +: ROW_BITS]   = it.row;
        word[IN_COL_LSB +: COL_BITS]   = it.col;
        word[IN_X_LSB   +: COORD_BITS] = it.x;
        word[IN_Y_LSB   +: COORD_BITS] = it.y;
        word[IN_Z_LSB   +: COORD_BITS] = it.z;
        word[IN_U_LSB   +: FRAC_BITS]  = it.u;
        word[IN_V_LSB   +: FRAC_BITS]  = it.v;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= it.action;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        record_item(it);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_row(ref t_patch_item plan[$], input logic [ACTION_BITS-1:0] action,
                           input int row, input int col, input t_coord x, input t_coord y,
                           input t_coord z, input t_frac u, input t_frac v,
                           input bit typed, input t_surface want);
        t_patch_item it;
        it.action = action;
        it.row    = t_row'(row);
        it.col    = t_col'(col);
        it.x      = x;
        it.y      = y;
        it.z      = z;
        it.u      = u;
        it.v      = v;
        it.typed  = typed;
        it.want   = want;
        plan = {plan, it};
    endtask

    initial begin
        t_patch_item plan [$];
        t_surface    range_err;
        t_surface    full_scale;
        t_surface    none;

        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= ACTION_LOAD;

        range_err.x = '0;
        range_err.y = '0;
        range_err.z = '0;
        range_err.err = 1'b1;
        full_scale.x = COORD_MAX;
        full_scale.y = COORD_MIN;
        full_scale.z = COORD_MAX;
        full_scale.err = 1'b0;
        none = '{default: '0};

        // patches hanging off the bottom, the right and the corner of the grid
        add_row(plan, ACTION_EVAL, 13, 0, COORD_MAX, COORD_MAX, COORD_MAX, '1, '1, 1, range_err);
        add_row(plan, ACTION_EVAL, 0, 13, COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, 1, range_err);
        add_row(plan, ACTION_EVAL, 15, 15, '0, '1, '0, '1, '0, 1, range_err);
        // fill the origin patch with full-scale points
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                add_row(plan, ACTION_LOAD, i, j, COORD_MAX, COORD_MIN, COORD_MAX,
                        '1, '1, 0, none);
        add_row(plan, ACTION_LOAD, 15, 15, COORD_MIN, COORD_MAX, '0, '1, '1, 0, none);
        // constant patch gives the constant back at both parameter ends
        add_row(plan, ACTION_EVAL, 0, 0, '0, '0, '0, '0, '0, 1, full_scale);
        add_row(plan, ACTION_EVAL, 0, 0, COORD_MAX, '0, '0, '1, '1, 1, full_scale);
        add_row(plan, ACTION_LOAD, 1, 2, COORD_MIN, COORD_MAX, '0, '0, '0, 0, none);
        add_row(plan, ACTION_LOAD, 2, 1, 16'sd12345, -16'sd1, 16'sd1, '0, '0, 0, none);
        add_row(plan, ACTION_EVAL, 0, 0, '0, '0, '0, '1, '0, 0, none);
        add_row(plan, ACTION_EVAL, 0, 0, '0, '0, '0, 12'd1, 12'd2048, 0, none);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) drive_item(plan[k]);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == PHASE_ITEMS) begin
                tx_idle_pct = 83;
                rx_idle_pct = 23;
            end
            if (k == 2 * PHASE_ITEMS) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_go     = 1'b1;
            end
            drive_item(random_item());
        end
        i_s_axis_tvalid <= 1'b0;

        while (surf_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls plus one long hold-off that backs the block up
    always @(posedge i_clk) begin
        if (hold_go && hold_left < 0) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_surface got;
        t_surface want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.x   = o_m_axis_tdata[0 +: COORD_BITS];
            got.y   = o_m_axis_tdata[COORD_BITS +: COORD_BITS];
            got.z   = o_m_axis_tdata[2 * COORD_BITS +: COORD_BITS];
            got.err = o_m_axis_tuser;
            if (surf_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected surface point x=%0d y=%0d z=%0d err=%0b",
                             got.x, got.y, got.z, got.err);
            end else begin
                want = surf_expected.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                    got.err !== want.err) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("surface point mismatch: expected x=%0d y=%0d z=%0d err=%0b, %s",
                                 want.x, want.y, want.z, want.err,
                                 $sformatf("got x=%0d y=%0d z=%0d err=%0b",
                                           got.x, got.y, got.z, got.err));
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
